// ----- design/dda_pkg.sv -----
// Shared constants, controller state type and command/status structs for the DDA line generator.
package dda_pkg;

    localparam int unsigned DEF_COORD_BITS = 11;
    localparam int unsigned DEF_FRAC_BITS  = 16;

    typedef enum logic [0:0] {
        ST_IDLE   = 1'b0,
        ST_DIVIDE = 1'b1
    } dda_state_t;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    typedef struct packed {
        logic load_start;
        logic advance;
        logic flag_error;
        logic div_step;
    } dda_cmd_t;

    typedef struct packed {
        logic steps_zero;
        logic line_active;
        logic div_last;
    } dda_status_t;

endpackage

// ----- design/dda_ifs.sv -----
// Valid/ready channel interfaces for line requests and plotted points.
interface dda_req_if #(
    parameter int unsigned COORD_BITS = 11
);
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, command, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, command, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dda_pt_if #(
    parameter int unsigned COORD_BITS = 11
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  last_point;
    logic                  no_line_error;

    modport source (output valid, point_x, point_y, last_point, no_line_error, input ready);
    modport sink   (input valid, point_x, point_y, last_point, no_line_error, output ready);
endinterface

// ----- design/dda_ctrl.sv -----
// Controller state machine: handshakes, division sequencing and datapath commands.
module dda_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_command,
    output logic                 in_ready,
    input  logic                 out_ready,
    output logic                 out_valid,
    input  dda_pkg::dda_status_t status,
    output dda_pkg::dda_cmd_t    cmd
);
    import dda_pkg::*;

    dda_state_t state_reg;
    dda_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_command == CMD_START) && !status.steps_zero)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and commands.
    always_comb
    begin
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_command == CMD_START)
                    begin
                        cmd.load_start = 1'b1;
                        out_valid_next = status.steps_zero;
                    end
                    else if (status.line_active)
                    begin
                        cmd.advance    = 1'b1;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        cmd.flag_error = 1'b1;
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- design/dda_datapath.sv -----
// Datapath: endpoint setup, restoring dividers for both increments on one step counter, accumulators, flags.
module dda_datapath #(
    parameter int unsigned COORD_BITS = dda_pkg::DEF_COORD_BITS,
    parameter int unsigned FRAC_BITS  = dda_pkg::DEF_FRAC_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dda_pkg::dda_cmd_t     cmd,
    output dda_pkg::dda_status_t  status,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic [COORD_BITS-1:0] point_x,
    output logic [COORD_BITS-1:0] point_y,
    output logic                  last_point,
    output logic                  no_line_error
);
    import dda_pkg::*;

    localparam int unsigned ACC_BITS = COORD_BITS + FRAC_BITS;
    localparam int unsigned INC_BITS = FRAC_BITS + 2;
    localparam int unsigned Q_BITS   = FRAC_BITS + 1;
    localparam int unsigned REM_BITS = COORD_BITS + 1;
    localparam int unsigned CNT_BITS = $clog2(FRAC_BITS + 1);
    localparam logic [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

    logic [ACC_BITS-1:0]   x_acc_reg, x_acc_next;
    logic [ACC_BITS-1:0]   y_acc_reg, y_acc_next;
    logic [INC_BITS-1:0]   x_inc_reg, x_inc_next;
    logic [INC_BITS-1:0]   y_inc_reg, y_inc_next;
    logic [COORD_BITS-1:0] steps_reg, steps_next;
    logic [COORD_BITS-1:0] remaining_reg, remaining_next;
    logic                  active_reg, active_next;
    logic                  last_reg, last_next;
    logic                  err_reg, err_next;
    logic                  x_neg_reg, x_neg_next;
    logic                  y_neg_reg, y_neg_next;
    logic [REM_BITS-1:0]   x_rem_reg, x_rem_next;
    logic [REM_BITS-1:0]   y_rem_reg, y_rem_next;
    logic [Q_BITS-1:0]     x_q_reg, x_q_next;
    logic [Q_BITS-1:0]     y_q_reg, y_q_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;

    logic                  x_neg_in, y_neg_in;
    logic [COORD_BITS-1:0] x_mag_in, y_mag_in, steps_in;
    logic [REM_BITS-1:0]   x_trial, y_trial, steps_ext;
    logic                  x_ge, y_ge;
    logic [REM_BITS-1:0]   x_rem_step, y_rem_step;
    logic [Q_BITS-1:0]     x_q_step, y_q_step;
    logic [ACC_BITS-1:0]   x_round, y_round;

    // Endpoint setup.
    always_comb
    begin
        x_neg_in = end_x < start_x;
        y_neg_in = end_y < start_y;
        x_mag_in = x_neg_in ? (start_x - end_x) : (end_x - start_x);
        y_mag_in = y_neg_in ? (start_y - end_y) : (end_y - start_y);
        steps_in = (x_mag_in > y_mag_in) ? x_mag_in : y_mag_in;
    end

    // One quotient bit per cycle; the first step yields the integer bit without shifting.
    always_comb
    begin
        steps_ext  = {1'b0, steps_reg};
        x_trial    = (cnt_reg == '0) ? x_rem_reg : {x_rem_reg[REM_BITS-2:0], 1'b0};
        y_trial    = (cnt_reg == '0) ? y_rem_reg : {y_rem_reg[REM_BITS-2:0], 1'b0};
        x_ge       = x_trial >= steps_ext;
        y_ge       = y_trial >= steps_ext;
        x_rem_step = x_ge ? (x_trial - steps_ext) : x_trial;
        y_rem_step = y_ge ? (y_trial - steps_ext) : y_trial;
        x_q_step   = {x_q_reg[Q_BITS-2:0], x_ge};
        y_q_step   = {y_q_reg[Q_BITS-2:0], y_ge};
    end

    always_comb
    begin
        x_acc_next     = x_acc_reg;
        y_acc_next     = y_acc_reg;
        x_inc_next     = x_inc_reg;
        y_inc_next     = y_inc_reg;
        steps_next     = steps_reg;
        remaining_next = remaining_reg;
        active_next    = active_reg;
        last_next      = last_reg;
        err_next       = err_reg;
        x_neg_next     = x_neg_reg;
        y_neg_next     = y_neg_reg;
        x_rem_next     = x_rem_reg;
        y_rem_next     = y_rem_reg;
        x_q_next       = x_q_reg;
        y_q_next       = y_q_reg;
        cnt_next       = cnt_reg;

        if (cmd.load_start)
        begin
            x_acc_next     = {start_x, {FRAC_BITS{1'b0}}};
            y_acc_next     = {start_y, {FRAC_BITS{1'b0}}};
            steps_next     = steps_in;
            remaining_next = steps_in;
            active_next    = steps_in != '0;
            last_next      = steps_in == '0;
            err_next       = 1'b0;
            x_neg_next     = x_neg_in;
            y_neg_next     = y_neg_in;
            x_rem_next     = {1'b0, x_mag_in};
            y_rem_next     = {1'b0, y_mag_in};
            x_q_next       = '0;
            y_q_next       = '0;
            cnt_next       = '0;
            if (steps_in == '0)
            begin
                x_inc_next = '0;
                y_inc_next = '0;
            end
        end
        else if (cmd.advance)
        begin
            x_acc_next     = x_acc_reg + {{(ACC_BITS-INC_BITS){x_inc_reg[INC_BITS-1]}}, x_inc_reg};
            y_acc_next     = y_acc_reg + {{(ACC_BITS-INC_BITS){y_inc_reg[INC_BITS-1]}}, y_inc_reg};
            remaining_next = remaining_reg - COORD_BITS'(1);
            last_next      = remaining_reg == COORD_BITS'(1);
            active_next    = remaining_reg != COORD_BITS'(1);
            err_next       = 1'b0;
        end
        else if (cmd.flag_error)
        begin
            last_next = 1'b0;
            err_next  = 1'b1;
        end
        else if (cmd.div_step)
        begin
            x_rem_next = x_rem_step;
            y_rem_next = y_rem_step;
            x_q_next   = x_q_step;
            y_q_next   = y_q_step;
            cnt_next   = cnt_reg + CNT_BITS'(1);
            if (status.div_last)
            begin
                x_inc_next = x_neg_reg ? (INC_BITS'(0) - {1'b0, x_q_step}) : {1'b0, x_q_step};
                y_inc_next = y_neg_reg ? (INC_BITS'(0) - {1'b0, y_q_step}) : {1'b0, y_q_step};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_acc_reg     <= '0;
            y_acc_reg     <= '0;
            x_inc_reg     <= '0;
            y_inc_reg     <= '0;
            remaining_reg <= '0;
            active_reg    <= 1'b0;
            last_reg      <= 1'b0;
            err_reg       <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            x_acc_reg     <= x_acc_next;
            y_acc_reg     <= y_acc_next;
            x_inc_reg     <= x_inc_next;
            y_inc_reg     <= y_inc_next;
            remaining_reg <= remaining_next;
            active_reg    <= active_next;
            last_reg      <= last_next;
            err_reg       <= err_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steps_reg <= steps_next;
        x_neg_reg <= x_neg_next;
        y_neg_reg <= y_neg_next;
        x_rem_reg <= x_rem_next;
        y_rem_reg <= y_rem_next;
        x_q_reg   <= x_q_next;
        y_q_reg   <= y_q_next;
    end

    assign status.steps_zero  = steps_in == '0;
    assign status.line_active = active_reg;
    assign status.div_last    = cnt_reg == CNT_BITS'(FRAC_BITS);

    // The accumulators only change when a new item is taken, so they hold the shown point.
    assign x_round       = x_acc_reg + HALF;
    assign y_round       = y_acc_reg + HALF;
    assign point_x       = x_round[ACC_BITS-1:FRAC_BITS];
    assign point_y       = y_round[ACC_BITS-1:FRAC_BITS];
    assign last_point    = last_reg;
    assign no_line_error = err_reg;

endmodule

// ----- design/dda_line_point_generator_top.sv -----
// Top level of the DDA line point generator: controller plus datapath on two item channels.
// A start item loads both endpoints, takes the step count as the larger of the x and y
// distances, and then runs restoring dividers for the x and y increments that share one step
// counter and work together, one quotient bit per cycle each, so the first point of a line
// appears once the division is complete after the start item is taken. A line of
// zero length, a next item and a next item with no active line each give their point in the
// cycle after acceptance, and a new item can be taken in that same cycle the point is
// presented if the consumer takes it, giving one point per cycle during a line. Points are the
// fixed-point accumulators rounded half up; the item that reaches the final step carries
// last_point, and a next item with no line in progress repeats the last point with
// no_line_error set and leaves the accumulators untouched. A start during a line abandons it.
module dda_line_point_generator_top #(
    parameter int unsigned COORD_BITS = dda_pkg::DEF_COORD_BITS,
    parameter int unsigned FRAC_BITS  = dda_pkg::DEF_FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    dda_req_if.sink     request,
    dda_pt_if.source    result
);
    import dda_pkg::*;

    dda_cmd_t    cmd;
    dda_status_t status;

    dda_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (request.valid),
        .in_command (request.command),
        .in_ready   (request.ready),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .status     (status),
        .cmd        (cmd)
    );

    dda_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .start_x       (request.start_x),
        .start_y       (request.start_y),
        .end_x         (request.end_x),
        .end_y         (request.end_y),
        .point_x       (result.point_x),
        .point_y       (result.point_y),
        .last_point    (result.last_point),
        .no_line_error (result.no_line_error)
    );

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the DDA line point generator, with its own prediction of every point.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dda_pkg::*;

    // Widths follow the block's default parameters. An accumulator holds the integer part
    // and the fraction, and an increment needs two integer bits so that +1.0 and -1.0 both fit.
    localparam int unsigned CW        = DEF_COORD_BITS;
    localparam int unsigned FW        = DEF_FRAC_BITS;
    localparam int unsigned ACC_W     = CW + FW;
    localparam int unsigned INC_W     = FW + 2;
    localparam int          COORD_MAX = (1 << CW) - 1;

    // The slowest item is a start, which has to wait for the divider to finish. The limit
    // is several times the slowest run: every item waiting out both sides' longest idle
    // stretches on top of the divider, plus the long hold-off of the backpressure test.
    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_CYCLES  = FW + 8;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int MAX_REPORTS   = 10;
    localparam int HOLD_OFF_LEN  = 300;

    typedef struct packed {
        logic [CW-1:0] point_x;
        logic [CW-1:0] point_y;
        logic          last_point;
        logic          no_line_error;
    } plotted_point_t;

    logic clk;
    logic rst_n;

    dda_req_if #(.COORD_BITS(CW)) request_ch ();
    dda_pt_if  #(.COORD_BITS(CW)) point_ch ();

    dda_line_point_generator_top #(
        .COORD_BITS (CW),
        .FRAC_BITS  (FW)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (point_ch)
    );

    // Points the predictor has worked out and the block has not yet delivered, oldest first.
    plotted_point_t expected_points[$];

    // The predictor's own copy of the line state.
    logic        [ACC_W-1:0] trace_x;
    logic        [ACC_W-1:0] trace_y;
    logic signed [INC_W-1:0] stride_x;
    logic signed [INC_W-1:0] stride_y;
    logic        [CW-1:0]    steps_left;
    logic                    line_open;

    // Idle controls. The test tasks switch these to get stretches with and without idling.
    bit gaps_on;
    bit stalls_on;
    int recv_wait;
    int hold_off_left;

    int fail_count;
    int report_count;
    int requests_sent;
    int cycle_count;

    // Free-running clock with an 8 ns period.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Runaway guard: if the run has not finished by the cycle limit, it has hung.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Point receiver. It changes ready only at the falling edge. A long hold-off, when one is
    // requested, takes precedence over the per-item wait that the checker draws on each point.
    initial
    begin
        point_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                point_ch.ready <= 1'b0;
                hold_off_left--;
            end
            else if (recv_wait > 0)
            begin
                point_ch.ready <= 1'b0;
                recv_wait--;
            end
            else
            begin
                point_ch.ready <= 1'b1;
            end
        end
    end

    // Point checker. Every point taken at a rising edge is compared field by field with the
    // oldest prediction. A point with nothing predicted is a failure as well.
    always @(posedge clk)
    begin
        plotted_point_t want;
        plotted_point_t got;
        if (rst_n && point_ch.valid && point_ch.ready)
        begin
            got.point_x       = point_ch.point_x;
            got.point_y       = point_ch.point_y;
            got.last_point    = point_ch.last_point;
            got.no_line_error = point_ch.no_line_error;
            if (expected_points.size() == 0)
            begin
                fail_count++;
                if (report_count < MAX_REPORTS)
                    $display("%0t: unexpected point x=%0d y=%0d last=%0b err=%0b", $realtime,
                             got.point_x, got.point_y, got.last_point, got.no_line_error);
                report_count++;
            end
            else
            begin
                want = expected_points.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (report_count < MAX_REPORTS)
                        $display({"%0t: point mismatch: expected x=%0d y=%0d last=%0b err=%0b,",
                                  " got x=%0d y=%0d last=%0b err=%0b"}, $realtime,
                                 want.point_x, want.point_y, want.last_point,
                                 want.no_line_error, got.point_x, got.point_y,
                                 got.last_point, got.no_line_error);
                    report_count++;
                end
            end
            recv_wait = stalls_on ? $urandom_range(0, 10) : 0;
        end
    end

    // Accumulator rounded half up to a pixel coordinate.
    function automatic logic [CW-1:0] round_half_up(logic [ACC_W-1:0] acc);
        logic [ACC_W:0] sum;
        sum = {1'b0, acc} + ((ACC_W + 1)'(1) << (FW - 1));
        return sum[ACC_W-1:FW];
    endfunction

    // Per-step increment d / steps in fixed point, truncated toward zero.
    function automatic logic signed [INC_W-1:0] step_increment(int d, int steps);
        longint q;
        q = (longint'(d < 0 ? -d : d) << FW) / steps;
        if (d < 0)
            q = -q;
        return INC_W'(q);
    endfunction

    function automatic int line_steps(int sx, int sy, int ex, int ey);
        int adx;
        int ady;
        adx = (ex > sx) ? ex - sx : sx - ex;
        ady = (ey > sy) ? ey - sy : sy - ey;
        return (adx > ady) ? adx : ady;
    endfunction

    function automatic logic [CW-1:0] clamp_coord(int v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return CW'(COORD_MAX);
        return CW'(v);
    endfunction

    // Works out the point that one accepted request produces and updates the line state.
    task automatic predict_point(logic cmd, logic [CW-1:0] sx, logic [CW-1:0] sy,
                                 logic [CW-1:0] ex, logic [CW-1:0] ey);
        int dx;
        int dy;
        int steps;
        plotted_point_t pt;
        pt.last_point    = 1'b0;
        pt.no_line_error = 1'b0;
        if (cmd == CMD_START)
        begin
            dx         = int'(ex) - int'(sx);
            dy         = int'(ey) - int'(sy);
            steps      = line_steps(int'(sx), int'(sy), int'(ex), int'(ey));
            trace_x    = {sx, {FW{1'b0}}};
            trace_y    = {sy, {FW{1'b0}}};
            steps_left = CW'(steps);
            if (steps == 0)
            begin
                // A line of zero length is finished with its one and only point.
                stride_x      = '0;
                stride_y      = '0;
                line_open     = 1'b0;
                pt.last_point = 1'b1;
            end
            else
            begin
                stride_x  = step_increment(dx, steps);
                stride_y  = step_increment(dy, steps);
                line_open = 1'b1;
            end
        end
        else if (line_open)
        begin
            trace_x = trace_x + {{(ACC_W - INC_W){stride_x[INC_W-1]}}, stride_x};
            trace_y = trace_y + {{(ACC_W - INC_W){stride_y[INC_W-1]}}, stride_y};
            if (steps_left != 0)
                steps_left--;
            if (steps_left == 0)
            begin
                line_open     = 1'b0;
                pt.last_point = 1'b1;
            end
        end
        else
        begin
            // Next with no line in progress repeats the held point and flags it.
            pt.no_line_error = 1'b1;
        end
        pt.point_x = round_half_up(trace_x);
        pt.point_y = round_half_up(trace_y);
        expected_points.push_back(pt);
    endtask

    // Offers one request and returns at the falling edge after it was taken. It is entered at
    // a falling edge. With no gap drawn, valid simply stays high for the next request.
    task automatic send_request(logic cmd, logic [CW-1:0] sx, logic [CW-1:0] sy,
                                logic [CW-1:0] ex, logic [CW-1:0] ey);
        int gap;
        gap = gaps_on ? $urandom_range(0, 10) : 0;
        if (gap != 0)
        begin
            request_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        request_ch.valid   <= 1'b1;
        request_ch.command <= cmd;
        request_ch.start_x <= sx;
        request_ch.start_y <= sy;
        request_ch.end_x   <= ex;
        request_ch.end_y   <= ey;
        do
            @(posedge clk);
        while (!request_ch.ready);
        predict_point(cmd, sx, sy, ex, ey);
        requests_sent++;
        @(negedge clk);
    endtask

    // A next request; its coordinate fields carry noise that the block must ignore.
    task automatic send_next();
        send_request(CMD_NEXT, CW'($urandom_range(0, COORD_MAX)),
                     CW'($urandom_range(0, COORD_MAX)), CW'($urandom_range(0, COORD_MAX)),
                     CW'($urandom_range(0, COORD_MAX)));
    endtask

    // A start followed by a number of next requests.
    task automatic send_line(int sx, int sy, int ex, int ey, int nexts);
        send_request(CMD_START, CW'(sx), CW'(sy), CW'(ex), CW'(ey));
        repeat (nexts) send_next();
    endtask

    // Right after reset there is no line, so next must give (0,0) with the error flag.
    task automatic test_no_line_after_reset();
        send_next();
    endtask

    // Lines of zero length give one final point, and the next request after it is an error
    // that repeats that point. Both corners of the coordinate range are used.
    task automatic test_zero_length();
        send_line(0, 0, 0, 0, 1);
        send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1);
    endtask

    // Increments of exactly one half hit the rounding boundary, and a third exercises the
    // truncation of the divided increment.
    task automatic test_rounding();
        send_line(0, 0, 2, 1, 2);
        send_line(10, 10, 7, 11, 4);
    endtask

    // Full-span diagonals in both directions and a steep line, each dropped part way by the
    // start that follows, so a start during an active line is covered too.
    task automatic test_extreme_spans();
        send_line(0, COORD_MAX, COORD_MAX, 0, 3);
        send_line(COORD_MAX, 0, 0, COORD_MAX, 2);
        send_line(0, 0, 5, COORD_MAX, 2);
        send_line(COORD_MAX, 3, COORD_MAX - 2, 0, 3);
    endtask

    // The receiver holds off for a long stretch while requests keep coming back to back, so
    // the block fills up and has to stall its input.
    task automatic test_backpressure();
        gaps_on       = 1'b0;
        hold_off_left = HOLD_OFF_LEN;
        send_line(100, 100, 112, 95, 12);
        send_line(40, 2000, 40, 2010, 10);
        gaps_on = 1'b1;
    endtask

    // Mostly complete lines with random content, plus aborted long lines, zero-length lines,
    // extra next requests past the end and stray next requests. The idle mode of both sides
    // is redrawn every so often so that there are stretches with and without gaps.
    task automatic test_random_lines();
        int target;
        int mode_switch;
        int kind;
        int span;
        int sx;
        int sy;
        int ex;
        int ey;
        int steps;
        target      = requests_sent + RANDOM_ITEMS;
        mode_switch = requests_sent;
        while (requests_sent < target)
        begin
            if (requests_sent >= mode_switch)
            begin
                gaps_on     = ($urandom_range(0, 3) != 0);
                stalls_on   = ($urandom_range(0, 3) != 0);
                mode_switch = requests_sent + 150;
            end
            kind = $urandom_range(0, 99);
            sx   = $urandom_range(0, COORD_MAX);
            sy   = $urandom_range(0, COORD_MAX);
            if (kind < 60 || (kind >= 82 && kind < 90))
            begin
                // Complete line; short ones mostly, now and then a longer one.
                span  = (kind < 60) ? $urandom_range(1, 24) : $urandom_range(25, 300);
                ex    = int'(clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span));
                ey    = int'(clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span));
                steps = line_steps(sx, sy, ex, ey);
                send_line(sx, sy, ex, ey, steps);
                if ($urandom_range(0, 4) == 0)
                    send_next();
            end
            else if (kind < 72)
            begin
                send_line(sx, sy, sx, sy, $urandom_range(0, 1));
            end
            else if (kind < 82)
            begin
                // Long line with fully random endpoints, abandoned by the next start.
                ex = $urandom_range(0, COORD_MAX);
                ey = $urandom_range(0, COORD_MAX);
                send_line(sx, sy, ex, ey, $urandom_range(0, 30));
            end
            else
            begin
                repeat ($urandom_range(1, 4)) send_next();
            end
        end
    endtask

    // Test sequence: reset, directed cases, backpressure, random lines, then drain and verdict.
    initial
    begin
        rst_n              = 1'b0;
        request_ch.valid   = 1'b0;
        request_ch.command = CMD_START;
        request_ch.start_x = '0;
        request_ch.start_y = '0;
        request_ch.end_x   = '0;
        request_ch.end_y   = '0;
        gaps_on            = 1'b1;
        stalls_on          = 1'b1;
        recv_wait          = 0;
        hold_off_left      = 0;
        fail_count         = 0;
        report_count       = 0;
        requests_sent      = 0;
        trace_x            = '0;
        trace_y            = '0;
        stride_x           = '0;
        stride_y           = '0;
        steps_left         = '0;
        line_open          = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_no_line_after_reset();
        test_zero_length();
        test_rounding();
        test_extreme_spans();
        test_backpressure();
        test_random_lines();

        request_ch.valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        // Let a stray extra point show up, if the block were to produce one.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
